>>> sv/qcnrp_pkg.sv
// Shared types, widths, register indexes and reset values for the QCN rate controller.
`timescale 1ns / 1ps

package qcnrp_pkg;

    localparam int RATE_BITS_DEF        = 40;
    localparam int FB_FRACTION_BITS_DEF = 15;

    localparam int LINK_W     = 40;
    localparam int STEP_W     = 30;
    localparam int MIN_W      = 40;
    localparam int PPC_W      = 16;
    localparam int PB_W       = 18;
    localparam int FB_W       = 16;
    localparam int CNT_W      = 16;
    localparam int OUT_RATE_W = 40;
    localparam int GAP_W      = 37;
    localparam int NS_W       = 30;
    localparam int DVD_W      = PB_W + NS_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [NS_W-1:0] NS_PER_S   = NS_W'(1000000000);
    localparam logic [63:0]     LIMIT_RATE = 64'd1000000000000;

    localparam logic [LINK_W-1:0] LINK_RATE_RST = LINK_W'(64'd10000000000);
    localparam logic [STEP_W-1:0] RATE_STEP_RST = STEP_W'(500000);
    localparam logic [MIN_W-1:0]  MIN_RATE_RST  = MIN_W'(1000000);
    localparam logic [PPC_W-1:0]  PPC_RST       = PPC_W'(100);
    localparam logic [PB_W-1:0]   PB_RST        = PB_W'(1500 * 8);

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_PER_CYC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_BITS = 3'd4;

    localparam logic OP_SENT     = 1'b0;
    localparam logic OP_FEEDBACK = 1'b1;

    typedef struct packed {
        logic                   op;
        logic signed [FB_W-1:0] feedback;
    } t_in;

    typedef struct packed {
        logic [OUT_RATE_W-1:0] current_rate;
        logic [OUT_RATE_W-1:0] target_rate;
        logic [GAP_W-1:0]      gap_ns;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD1,
        S_UPD2,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

endpackage

>>> sv/qcn_reaction_point_rate_control.sv
// Top level of the QCN reaction-point rate controller with its sequencer and serial multipliers.
`timescale 1ns / 1ps
// An accepted request runs the serial multiply, the update states S_UPD1 and S_UPD2, the divider
// start and the divide in turn; the divide is skipped when the gap saturates or the rate is zero,
// and a waiting output holds the result in S_OUT. One request is taken at a time: an 18-step serial
// multiply and a 37-step bit-serial gap divider run in turn before the next request is taken.
// Synchronous reset loads the register defaults, sets both rates to the capped link rate
// and clears the counters; a write of the link rate does the same for the rates and counters.

module qcn_reaction_point_rate_control
    import qcnrp_pkg::*;
#(
    parameter int RATE_BITS        = RATE_BITS_DEF,
    parameter int FB_FRACTION_BITS = FB_FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LINK_W-1:0]    i_cfg_data
);

    localparam int PW     = RATE_BITS + FB_W;
    localparam int DW     = PW - FB_FRACTION_BITS - 1;
    localparam int MCNT_W = $clog2(PB_W + 1);
    localparam logic [63:0] ALL_ONES64 = (64'd1 << RATE_BITS) - 64'd1;
    localparam logic [63:0] CAP64 = (ALL_ONES64 < LIMIT_RATE) ? ALL_ONES64 : LIMIT_RATE;
    localparam logic [RATE_BITS-1:0] RATE_CAP = CAP64[RATE_BITS-1:0];
    localparam logic [63:0] RST64 =
        (64'(LINK_RATE_RST) > CAP64) ? CAP64 : 64'(LINK_RATE_RST);
    localparam logic [RATE_BITS-1:0] RATE_RST = RST64[RATE_BITS-1:0];

    t_state r_state;
    t_state n_state;

    logic [STEP_W-1:0]    r_step;
    logic [MIN_W-1:0]     r_min;
    logic [PPC_W-1:0]     r_ppc;
    logic [PB_W-1:0]      r_pb;

    logic [RATE_BITS-1:0] r_now;
    logic [RATE_BITS-1:0] r_goal;
    logic [CNT_W-1:0]     r_rc;
    logic [CNT_W-1:0]     r_sent;
    logic [RATE_BITS-1:0] n_now;
    logic [RATE_BITS-1:0] n_goal;
    logic [CNT_W-1:0]     n_rc;
    logic [CNT_W-1:0]     n_sent;

    logic                 r_op;
    logic                 r_neg;
    logic [MCNT_W-1:0]    r_mcnt;
    logic [FB_W-1:0]      r_fb_mul;
    logic [PW-1:0]        r_fb_mcand;
    logic [PW-1:0]        r_prod;
    logic [PB_W-1:0]      r_pb_mul;
    logic [DVD_W-1:0]     r_ns_mcand;
    logic [DVD_W-1:0]     r_dvd;
    logic [RATE_BITS-1:0] r_tmp;
    logic [RATE_BITS-1:0] n_tmp;

    logic                 r_out_valid;
    t_out                 r_out;
    t_out                 n_out;

    logic                 cfg_we;
    logic                 in_acc;
    logic                 out_load;
    logic                 div_start;
    logic                 div_done;
    logic [GAP_W-1:0]     div_quot;

    logic [FB_W-1:0]      fb_raw;
    logic [FB_W-1:0]      fb_mag;
    logic [DW-1:0]        delta;
    logic [63:0]          now64;
    logic [63:0]          delta64;
    logic [63:0]          fb_sum64;
    logic [63:0]          fb_tmp64;
    logic [63:0]          step_sum64;
    logic [63:0]          link64;
    logic [63:0]          floor64;
    logic [63:0]          fb_new64;
    logic [CNT_W-1:0]     sent_inc;
    logic                 cycle_done;
    logic [RATE_BITS:0]   mid_sum;

    assign cfg_we = i_cfg_valid && o_cfg_ready;
    assign in_acc = i_in_valid && !o_in_stall;

    assign fb_raw = i_in.feedback;
    assign fb_mag = fb_raw[FB_W-1] ? (~fb_raw + 1'b1) : fb_raw;

    // First update cycle: the new target after a recovery cycle, or the scaled rate.
    assign delta      = DW'(r_prod >> (FB_FRACTION_BITS + 1));
    assign now64      = 64'(r_now);
    assign delta64    = 64'(delta);
    assign fb_sum64   = now64 + delta64;
    assign step_sum64 = 64'(r_goal) + 64'(r_step);

    always_comb begin
        if (r_neg) begin
            fb_tmp64 = (delta64 >= now64) ? 64'd0 : (now64 - delta64);
        end else begin
            fb_tmp64 = (fb_sum64 > CAP64) ? CAP64 : fb_sum64;
        end
        if (r_op == OP_FEEDBACK) begin
            n_tmp = RATE_BITS'(fb_tmp64);
        end else begin
            n_tmp = (step_sum64 > CAP64) ? RATE_CAP : RATE_BITS'(step_sum64);
        end
    end

    // Second update cycle: counters, midpoint, floor and cap.
    assign sent_inc   = r_sent + 1'b1;
    assign cycle_done = sent_inc >= r_ppc;
    assign mid_sum    = {1'b0, r_now} + {1'b0, r_tmp};
    assign floor64    = (64'(r_tmp) < 64'(r_min)) ? 64'(r_min) : 64'(r_tmp);
    assign fb_new64   = (floor64 > CAP64) ? CAP64 : floor64;
    assign link64     = (64'(i_cfg_data) > CAP64) ? CAP64 : 64'(i_cfg_data);

    always_comb begin
        n_now  = r_now;
        n_goal = r_goal;
        n_rc   = r_rc;
        n_sent = r_sent;
        if (cfg_we && (i_cfg_index == CFG_LINK_RATE)) begin
            n_now  = RATE_BITS'(link64);
            n_goal = RATE_BITS'(link64);
            n_rc   = '0;
            n_sent = '0;
        end else if (r_state == S_UPD2) begin
            if (r_op == OP_FEEDBACK) begin
                if (r_rc != '0) begin
                    n_goal = r_now;
                end
                n_rc   = '0;
                n_sent = '0;
                n_now  = RATE_BITS'(fb_new64);
            end else if (cycle_done) begin
                if (r_rc != '1) begin
                    n_rc = r_rc + 1'b1;
                end
                n_sent = '0;
                n_goal = r_tmp;
                n_now  = mid_sum[RATE_BITS:1];
            end else begin
                n_sent = sent_inc;
            end
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:   n_state = in_acc ? S_MUL : S_IDLE;
            S_MUL:    n_state = (r_mcnt == MCNT_W'(1)) ? S_UPD1 : S_MUL;
            S_UPD1:   n_state = S_UPD2;
            S_UPD2:   n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    n_state = div_done ? S_OUT : S_DIV;
            S_OUT:    n_state = out_load ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall  = i_cfg_valid;
                o_cfg_ready = 1'b1;
            end
            S_DSTART: begin
                div_start = 1'b1;
            end
            S_OUT: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out.current_rate = OUT_RATE_W'(r_now);
        n_out.target_rate  = OUT_RATE_W'(r_goal);
        n_out.gap_ns       = div_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= RATE_STEP_RST;
            r_min       <= MIN_RATE_RST;
            r_ppc       <= PPC_RST;
            r_pb        <= PB_RST;
            r_now       <= RATE_RST;
            r_goal      <= RATE_RST;
            r_rc        <= '0;
            r_sent      <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_goal  <= n_goal;
            r_rc    <= n_rc;
            r_sent  <= n_sent;
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_RATE_STEP:   r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_MIN_RATE:    r_min  <= i_cfg_data[MIN_W-1:0];
                    CFG_PKT_PER_CYC: r_ppc  <= i_cfg_data[PPC_W-1:0];
                    CFG_PACKET_BITS: r_pb   <= i_cfg_data[PB_W-1:0];
                    default:         r_step <= r_step;
                endcase
            end
            if (in_acc) begin
                r_mcnt <= MCNT_W'(PB_W);
            end else if (r_state == S_MUL) begin
                r_mcnt <= r_mcnt - 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Two shift-add multipliers share the sequence: rate times feedback magnitude, and
    // packet bits times one billion for the gap dividend.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_in.op;
            r_neg      <= fb_raw[FB_W-1];
            r_fb_mul   <= fb_mag;
            r_fb_mcand <= PW'(r_now);
            r_prod     <= '0;
            r_pb_mul   <= r_pb;
            r_ns_mcand <= DVD_W'(NS_PER_S);
            r_dvd      <= '0;
        end else if (r_state == S_MUL) begin
            if (r_fb_mul[0]) begin
                r_prod <= r_prod + r_fb_mcand;
            end
            if (r_pb_mul[0]) begin
                r_dvd <= r_dvd + r_ns_mcand;
            end
            r_fb_mcand <= r_fb_mcand << 1;
            r_fb_mul   <= r_fb_mul >> 1;
            r_ns_mcand <= r_ns_mcand << 1;
            r_pb_mul   <= r_pb_mul >> 1;
        end
        if (r_state == S_UPD1) begin
            r_tmp <= n_tmp;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    qcnrp_gap_div #(
        .RATE_BITS (RATE_BITS)
    ) u_gap_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_now),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_rate_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_now <= RATE_CAP) && (r_goal <= RATE_CAP))
        else $error("rate register above the rate cap");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_fb_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD2) && (r_op == OP_FEEDBACK)) |=> ((r_rc == '0) && (r_sent == '0)))
        else $error("feedback request did not clear the counters");
`endif

endmodule

>>> sv/qcnrp_gap_div.sv
// Bit-serial restoring divider that turns the gap dividend and the current rate into a gap.
`timescale 1ns / 1ps

module qcnrp_gap_div
    import qcnrp_pkg::*;
#(
    parameter int RATE_BITS = RATE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVD_W-1:0]     i_dividend,
    input  logic [RATE_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [GAP_W-1:0]     o_quot
);

    localparam int DCNT_W = $clog2(GAP_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DCNT_W-1:0]    r_cnt;
    logic [RATE_BITS-1:0] r_rem;
    logic [GAP_W-1:0]     r_quo;

    logic [RATE_BITS-1:0] hi;
    logic                 bypass;
    logic [RATE_BITS:0]   trial;
    logic                 ge;
    logic [RATE_BITS-1:0] n_rem;

    // A quotient that needs more than GAP_W bits, or a zero rate, saturates at once.
    assign hi     = RATE_BITS'(i_dividend[DVD_W-1:GAP_W]);
    assign bypass = (i_divisor == '0) || (hi >= i_divisor);
    assign trial  = {r_rem, r_quo[GAP_W-1]};
    assign ge     = trial >= {1'b0, i_divisor};
    assign n_rem  = ge ? RATE_BITS'(trial - {1'b0, i_divisor}) : trial[RATE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (bypass) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= DCNT_W'(GAP_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (bypass) begin
                r_quo <= '1;
            end else begin
                r_rem <= hi;
                r_quo <= i_dividend[GAP_W-1:0];
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[GAP_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
